// ----- rtl/core/timed_message_slot_table_macros.svh -----
// Assertion macros used by the message slot table datapath.
`ifndef TIMED_MESSAGE_SLOT_TABLE_MACROS_SVH
`define TIMED_MESSAGE_SLOT_TABLE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TMST_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TMST_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TMST_ASSERT(label, clk, rst, prop, msg)
`define TMST_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- rtl/core/tmst_pkg.sv -----
// Types and constants of the message slot table.
`timescale 1ns / 1ps
package tmst_pkg;

   typedef struct packed {
      logic [15:0]        text;
      logic [15:0]        ticks;
      logic signed [15:0] prio;
      logic [7:0]         color;
      logic signed [11:0] y;
      logic signed [11:0] x;
   } entry_type;

   typedef enum logic [1:0] {
      MODE_SHOW   = 2'd0,
      MODE_CENTER = 2'd1,
      MODE_TICK   = 2'd2,
      MODE_READ   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DISPATCH, ST_WALK, ST_DRAIN, ST_WRITE, ST_TFIN, ST_RWAIT, ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;       // capture item
      logic start;      // reset walk pointers
      logic issue;      // read entry at walk pointer
      logic rd_item;    // read entry at read_index
      logic wr_show;    // write new entry
      logic tick_done;  // commit compacted count
      logic rd_take;    // take read data as result
      logic emit;       // load output register
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     full;
      logic     empty;
      logic     read_ok;
      logic     walk_last;
      logic     out_free;
   } stat_type;

   localparam logic        REG_FONT_WIDTH    = 1'b0;
   localparam logic        REG_DISPLAY_TICKS = 1'b1;
   localparam logic [4:0]  FONT_WIDTH_RST    = 5'd8;
   localparam logic [15:0] DISPLAY_TICKS_RST = 16'd1000;
   localparam logic signed [13:0] CENTER_SPAN = 14'sd224;
   localparam logic signed [13:0] X_MIN       = -14'sd2048;
   localparam logic signed [13:0] X_MAX       = 14'sd2047;

endpackage

// ----- rtl/core/tmst_ctrl.sv -----
// Sequencer of the message slot table.
`timescale 1ns / 1ps
module tmst_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  tmst_pkg::stat_type stat,
   output tmst_pkg::cmd_type  cmd
);
   import tmst_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_tvalid) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            case (stat.mode)
               MODE_SHOW, MODE_CENTER: state_in = stat.full ? ST_WALK : ST_WRITE;
               MODE_TICK:              state_in = stat.empty ? ST_EMIT : ST_WALK;
               default:                state_in = stat.read_ok ? ST_RWAIT : ST_EMIT;
            endcase
         end
         ST_WALK:  if (stat.walk_last) state_in = ST_DRAIN;
         ST_DRAIN: state_in = (stat.mode == MODE_TICK) ? ST_TFIN : ST_WRITE;
         ST_WRITE: state_in = ST_EMIT;
         ST_TFIN:  state_in = ST_EMIT;
         ST_RWAIT: state_in = ST_EMIT;
         ST_EMIT:  if (stat.out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_DISPATCH: begin
            case (stat.mode)
               MODE_SHOW, MODE_CENTER: cmd.start = stat.full;
               MODE_TICK:              cmd.start = !stat.empty;
               default:                cmd.rd_item = stat.read_ok;
            endcase
         end
         ST_WALK:  cmd.issue     = 1'b1;
         ST_WRITE: cmd.wr_show   = 1'b1;
         ST_TFIN:  cmd.tick_done = 1'b1;
         ST_RWAIT: cmd.rd_take   = 1'b1;
         ST_EMIT:  cmd.emit      = stat.out_free;
         default:  cmd = '0;
      endcase
   end

endmodule

// ----- rtl/core/tmst_datapath.sv -----
// Entry store, walk pointers, centering math and result register.
`timescale 1ns / 1ps
`include "timed_message_slot_table_macros.svh"
module tmst_datapath #(
   parameter int MAX_ENTRIES = 8,
   parameter int IDX_W       = 3,
   parameter int CNT_W       = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  tmst_pkg::cmd_type  cmd,
   output tmst_pkg::stat_type stat,
   input  logic [95:0]        req_tdata,
   input  logic [1:0]         req_tuser,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [87:0]        rsp_tdata,
   output logic               rsp_tuser
);
   import tmst_pkg::*;

   localparam int CMP_W = (CNT_W > 3) ? CNT_W : 3;

   // configuration
   logic [4:0]  font_ff;
   logic [15:0] life_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         font_ff <= FONT_WIDTH_RST;
         life_ff <= DISPLAY_TICKS_RST;
      end else if (csr_wr_en) begin
         if (csr_index == REG_FONT_WIDTH) font_ff <= csr_wdata[4:0];
         else                             life_ff <= csr_wdata;
      end
   end

   // captured item
   mode_type           mode_ff;
   logic [15:0]        text_ff;
   logic signed [11:0] x_ff, y_ff;
   logic [7:0]         color_ff;
   logic signed [15:0] prio_ff;
   logic [7:0]         len_ff;
   logic [15:0]        dt_ff;
   logic [2:0]         ridx_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= mode_type'(req_tuser);
         text_ff  <= req_tdata[15:0];
         x_ff     <= req_tdata[27:16];
         y_ff     <= req_tdata[39:28];
         color_ff <= req_tdata[47:40];
         prio_ff  <= req_tdata[63:48];
         len_ff   <= req_tdata[71:64];
         dt_ff    <= req_tdata[87:72];
         ridx_ff  <= req_tdata[90:88];
      end
   end

   // centered x: (224 - len*font)/2 toward zero, saturated
   logic [12:0]        prod;
   logic signed [13:0] diff, adj, half;
   logic signed [11:0] cx;

   always_comb begin
      prod = 13'(len_ff) * 13'(font_ff);
      diff = CENTER_SPAN - $signed({1'b0, prod});
      adj  = diff + $signed({13'd0, diff[13]});
      half = adj >>> 1;
      if (half < X_MIN)      cx = X_MIN[11:0];
      else if (half > X_MAX) cx = X_MAX[11:0];
      else                   cx = half[11:0];
   end

   entry_type new_entry;
   always_comb begin
      new_entry.text  = text_ff;
      new_entry.ticks = life_ff;
      new_entry.color = color_ff;
      new_entry.y     = y_ff;
      new_entry.prio  = (mode_ff == MODE_CENTER) ? 16'sd0 : prio_ff;
      new_entry.x     = (mode_ff == MODE_CENTER) ? cx : x_ff;
   end

   // entry store and walk
   entry_type         mem [MAX_ENTRIES];
   entry_type         rd_data_ff;
   logic              rd_vld_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic [IDX_W-1:0]  ptr_ff;
   logic [CNT_W-1:0]  wr_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic signed [15:0] best_prio_ff;
   logic              best_set_ff;

   logic              full, keep, take;
   logic [16:0]       left;
   logic [IDX_W-1:0]  slot, raddr, waddr;
   logic [CNT_W-1:0]  limit;
   logic              we;
   entry_type         wdata;

   always_comb begin
      full  = (count_ff == CNT_W'(MAX_ENTRIES));
      slot  = full ? best_idx_ff : IDX_W'(count_ff);
      limit = (mode_ff == MODE_TICK) ? count_ff : CNT_W'(MAX_ENTRIES);
      left  = {1'b0, rd_data_ff.ticks} - {1'b0, dt_ff};
      keep  = rd_vld_ff && (mode_ff == MODE_TICK) && !left[16] && (left != 17'd0);
      take  = rd_vld_ff && (mode_ff != MODE_TICK) &&
              (!best_set_ff || (rd_data_ff.prio < best_prio_ff));
      raddr = cmd.rd_item ? IDX_W'(ridx_ff) : ptr_ff;
      we    = cmd.wr_show || keep;
      waddr = cmd.wr_show ? slot : IDX_W'(wr_ptr_ff);
      wdata = rd_data_ff;
      wdata.ticks = left[15:0];
      if (cmd.wr_show) wdata = new_entry;
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_data_ff <= mem[raddr];
      rd_idx_ff  <= ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         count_ff    <= '0;
         ptr_ff      <= '0;
         wr_ptr_ff   <= '0;
         best_set_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.issue;
         if (cmd.start) begin
            ptr_ff      <= '0;
            wr_ptr_ff   <= '0;
            best_set_ff <= 1'b0;
         end else begin
            if (cmd.issue) ptr_ff <= ptr_ff + IDX_W'(1);
            if (keep)      wr_ptr_ff <= wr_ptr_ff + CNT_W'(1);
            if (take)      best_set_ff <= 1'b1;
         end
         if (cmd.wr_show && !full) count_ff <= count_ff + CNT_W'(1);
         else if (cmd.tick_done)   count_ff <= wr_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff  <= rd_idx_ff;
         best_prio_ff <= rd_data_ff.prio;
      end
   end

   // result and output register
   entry_type res_ff;
   logic      res_found_ff;
   logic [2:0] res_slot_ff;
   logic      rsp_tvalid_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_ff       <= '0;
         res_found_ff <= 1'b0;
         res_slot_ff  <= '0;
      end else if (cmd.wr_show) begin
         res_ff      <= new_entry;
         res_slot_ff <= 3'(slot);
      end else if (cmd.rd_take) begin
         res_ff       <= rd_data_ff;
         res_found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)               rsp_tvalid_ff <= 1'b0;
      else if (cmd.emit)       rsp_tvalid_ff <= 1'b1;
      else if (rsp_tready)     rsp_tvalid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_tdata <= {1'b0, res_slot_ff, res_ff.ticks, res_ff.text, res_ff.prio,
                       res_ff.color, res_ff.y, res_ff.x, 4'(count_ff)};
         rsp_tuser <= res_found_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      stat.mode      = mode_ff;
      stat.full      = full;
      stat.empty     = (count_ff == '0);
      stat.read_ok   = (CMP_W'(ridx_ff) < CMP_W'(count_ff)) &&
                       (CMP_W'(ridx_ff) < CMP_W'(MAX_ENTRIES));
      stat.walk_last = (CNT_W'(ptr_ff) == limit - CNT_W'(1));
      stat.out_free  = !rsp_tvalid_ff || rsp_tready;
   end

   `TMST_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(MAX_ENTRIES), "count over capacity")
   `TMST_ASSERT(a_compact_behind, clock, reset, rd_vld_ff |-> (CNT_W'(rd_idx_ff) >= wr_ptr_ff), "compaction write passed read")
   `TMST_ASSERT(a_count_step, clock, reset, cmd.wr_show |=> (count_ff == $past(count_ff) + CNT_W'(!$past(full))), "show count step wrong")

endmodule

// ----- rtl/core/timed_message_slot_table.sv -----
// Message slot table: top level joining sequencer and datapath.
`timescale 1ns / 1ps
// Holds up to MAX_ENTRIES timed messages in a one-read, one-write entry memory. One item is
// worked at a time. A show with free room writes straight into the next free slot, and a read
// of a live entry reads it; a read of a dead entry or a tick of an empty table does neither. A
// show into a full table first does one memory read per entry while looking for the lowest
// priority, and a tick does one read and at most one compacting write per live entry. A
// finished result sits in the output register while the next item is taken in; if it is still
// not taken when the next result is ready, the block stalls until it is. Entries hold no reset
// value; reset clears the live count, the walk pointers, the configuration and the output valid.
module timed_message_slot_table #(
   parameter int MAX_ENTRIES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // text_handle, x_pos, y_pos, ink_color, prio_level, text_length, tick_ms, read_index
   input  logic [95:0] req_tdata,
   // mode
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // active_count, out_x, out_y, out_color, out_prio, out_text, out_ticks, slot_used
   output logic [87:0] rsp_tdata,
   // entry_found
   output logic        rsp_tuser,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import tmst_pkg::*;

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   cmd_type  cmd;
   stat_type stat;

   tmst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tmst_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- tb/timed_message_slot_table_checker.sv -----
// Checker for the message slot table: predicts each result and compares it.
`timescale 1ns / 1ps
module timed_message_slot_table_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [87:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending_count,
   output int          result_count
);
   import tmst_pkg::*;

   typedef struct packed {
      logic [3:0]         count;
      logic signed [11:0] x;
      logic signed [11:0] y;
      logic [7:0]         color;
      logic signed [15:0] prio;
      logic [15:0]        text;
      logic [15:0]        ticks;
      logic [2:0]         slot;
      logic               found;
   } slot_result_type;

   localparam int SLOTS = 8;

   entry_type       table_q[SLOTS];
   int              live_q;
   logic [4:0]      font_width_q;
   logic [15:0]     lifetime_q;
   slot_result_type expected_results[$];

   function automatic slot_result_type pack_entry(int k);
      slot_result_type r;
      r = '0;
      r.x = table_q[k].x;
      r.y = table_q[k].y;
      r.color = table_q[k].color;
      r.prio = table_q[k].prio;
      r.text = table_q[k].text;
      r.ticks = table_q[k].ticks;
      return r;
   endfunction

   // Advances the predicted table by one item and returns its result.
   function automatic slot_result_type predict_slot_table(logic [1:0] mode, logic [95:0] d);
      slot_result_type r;
      entry_type       e;
      int              slot, lowest, w, left, cx;
      r = '0;
      e.text  = d[15:0];
      e.x     = d[27:16];
      e.y     = d[39:28];
      e.color = d[47:40];
      e.prio  = d[63:48];
      e.ticks = lifetime_q;
      case (mode_type'(mode))
         MODE_SHOW, MODE_CENTER: begin
            if (mode_type'(mode) == MODE_CENTER) begin
               cx = (224 - int'(d[71:64]) * int'(font_width_q)) / 2;
               if (cx < -2048) cx = -2048;
               if (cx > 2047) cx = 2047;
               e.x = cx[11:0];
               e.prio = '0;
            end
            if (live_q < SLOTS) begin
               slot = live_q;
               live_q++;
            end else begin
               lowest = 32'h7FFFFFFF;
               slot = 0;
               for (int i = 0; i < SLOTS; i++)
                  if (int'(table_q[i].prio) < lowest) begin
                     lowest = table_q[i].prio;
                     slot = i;
                  end
            end
            table_q[slot] = e;
            r = pack_entry(slot);
            r.slot = slot[2:0];
         end
         MODE_TICK: begin
            w = 0;
            for (int i = 0; i < live_q; i++) begin
               left = int'(table_q[i].ticks) - int'(d[87:72]);
               if (left > 0) begin
                  table_q[w] = table_q[i];
                  table_q[w].ticks = left[15:0];
                  w++;
               end
            end
            live_q = w;
         end
         default: begin
            if (int'(d[90:88]) < live_q) begin
               r = pack_entry(int'(d[90:88]));
               r.found = 1'b1;
            end
         end
      endcase
      r.count = live_q[3:0];
      return r;
   endfunction

   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      slot_result_type got, want;
      if (reset) begin
         live_q = 0;
         font_width_q = 5'd8;
         lifetime_q = 16'd1000;
         fail_count = 0;
         result_count <= 0;
         expected_results.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == REG_FONT_WIDTH) font_width_q = csr_wdata[4:0];
            else lifetime_q = csr_wdata;
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_slot_table(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            result_count <= result_count + 1;
            got = {rsp_tdata[3:0], rsp_tdata[15:4], rsp_tdata[27:16], rsp_tdata[35:28],
                   rsp_tdata[51:36], rsp_tdata[67:52], rsp_tdata[83:68], rsp_tdata[86:84],
                   rsp_tuser};
            if (expected_results.size() == 0) begin
               fail_count = fail_count + 1;
               if (fail_count <= 10) $display("unexpected result %h", got);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  fail_count = fail_count + 1;
                  if (fail_count <= 10)
                     $display("result %0d: expected cnt=%0d fnd=%0d x=%0d y=%0d col=%0d pri=%0d txt=%h tck=%0d slot=%0d / got cnt=%0d fnd=%0d x=%0d y=%0d col=%0d pri=%0d txt=%h tck=%0d slot=%0d",
                        result_count, want.count, want.found, want.x, want.y, want.color,
                        want.prio, want.text, want.ticks, want.slot, got.count, got.found,
                        got.x, got.y, got.color, got.prio, got.text, got.ticks, got.slot);
               end
            end
         end
      end
   end

endmodule

// ----- tb/tb_timed_message_slot_table.sv -----
// Testbench top for the message slot table: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_timed_message_slot_table;
   import tmst_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_wdata = '0;
   int          fail_count, pending_count, result_count;
   int          send_idle_pct = 0, recv_idle_pct = 0;
   int          quiet_cycles = 0, items_sent = 0;

   always #10 clock = ~clock;

   timed_message_slot_table u_top (.*);

   timed_message_slot_table_checker u_checker (.*);

   always @(posedge clock)
      rsp_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);

   // Watchdog on cycles with no accepted item on either channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // tvalid stays up after an accept until the next item or an idle cycle replaces it
   task automatic send_item(mode_type m, logic [15:0] txt, logic [11:0] x, logic [11:0] y,
                            logic [7:0] col, logic [15:0] pri, logic [7:0] len,
                            logic [15:0] dt, logic [2:0] ridx);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= m;
      req_tdata <= {5'd0, ridx, dt, len, pri, col, y, x, txt};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_random(bit shows_only);
      mode_type m;
      logic [15:0] dt;
      m = mode_type'($urandom_range(3));
      if (shows_only) m = mode_type'($urandom_range(1));
      dt = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(400));
      send_item(m, 16'($urandom), 12'($urandom), 12'($urandom), 8'($urandom),
                16'($urandom), 8'($urandom), dt, 3'($urandom));
   endtask

   task automatic write_reg(logic idx, logic [15:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: fill, evict by lowest prio, extremes, centering, reads, ticks.
      send_item(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 3'd0);
      send_item(MODE_SHOW, 16'hFFFF, 12'h7FF, 12'h800, 8'hFF, 16'h7FFF, 0, 0, 0);
      send_item(MODE_SHOW, 16'h0000, 12'h800, 12'h7FF, 8'h00, 16'h8000, 0, 0, 0);
      send_item(MODE_CENTER, 16'h1234, 0, 12'h123, 8'h5A, 16'h1111, 8'd255, 0, 0);
      send_item(MODE_CENTER, 16'h4321, 0, 12'hF00, 8'hA5, 0, 8'd0, 0, 0);
      for (int i = 0; i < 5; i++)
         send_item(MODE_SHOW, 16'(i), 12'(i), 12'(i), 8'(i), 16'(i - 2), 0, 0, 0);
      send_item(MODE_SHOW, 16'hBEEF, 12'h10, 12'h20, 8'h30, 16'hFFFF, 0, 0, 0);
      for (int i = 0; i < 8; i++) send_item(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 3'(i));
      send_item(MODE_TICK, 0, 0, 0, 0, 0, 0, 16'd0, 0);
      send_item(MODE_TICK, 0, 0, 0, 0, 0, 0, 16'd999, 0);
      send_item(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 3'd0);
      send_item(MODE_TICK, 0, 0, 0, 0, 0, 0, 16'hFFFF, 0);
      settle();
      // Zero font width and zero lifetime, then maximum font width and lifetime.
      write_reg(REG_FONT_WIDTH, 16'd0);
      write_reg(REG_DISPLAY_TICKS, 16'd0);
      send_item(MODE_CENTER, 16'h0001, 0, 0, 8'd1, 0, 8'd200, 0, 0);
      send_item(MODE_TICK, 0, 0, 0, 0, 0, 0, 16'd0, 0);
      settle();
      write_reg(REG_FONT_WIDTH, 16'd31);
      write_reg(REG_DISPLAY_TICKS, 16'hFFFF);
      send_item(MODE_CENTER, 16'h0002, 0, 0, 8'd2, 0, 8'd255, 0, 0);
      settle();
      // Random phases across idling profiles and register settings.
      for (int ph = 0; ph < 6; ph++) begin
         send_idle_pct = (ph % 3 == 0) ? 13 : (ph % 3 == 1) ? 69 : 0;
         recv_idle_pct = (ph % 3 == 0) ? 69 : (ph % 3 == 1) ? 13 : 0;
         write_reg(REG_FONT_WIDTH, 16'($urandom_range(ph == 5 ? 1 : 16, ph == 3 ? 1 : 31)));
         write_reg(REG_DISPLAY_TICKS, (ph == 4) ? 16'd1 : 16'($urandom_range(1, 2000)));
         for (int n = 0; n < 165; n++) send_random(($urandom_range(2) == 0));
         settle();
      end
      $display("Covered %0d items and %0d results: shows, centered shows, ticks, reads,",
               items_sent, result_count);
      $display("full-table eviction, and register extremes under three idling profiles.");
      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- timed_message_slot_table.f -----
+incdir+rtl/core
rtl/core/tmst_pkg.sv
rtl/core/tmst_ctrl.sv
rtl/core/tmst_datapath.sv
rtl/core/timed_message_slot_table.sv
tb/timed_message_slot_table_checker.sv
tb/tb_timed_message_slot_table.sv
